// File: rtl/decimal_exit_status_parser_top_macros.svh
// ----------------------------------------------------------------------------
// decimal exit status parser assertion macros
// shared concurrent assertion helpers, clocked on i_clk, off during reset
// ----------------------------------------------------------------------------
`ifndef DECIMAL_EXIT_STATUS_PARSER_TOP_MACROS_SVH
`define DECIMAL_EXIT_STATUS_PARSER_TOP_MACROS_SVH

// property that holds in every cycle
`define DEXP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// same-cycle implication
`define DEXP_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define DEXP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/dexp_pkg.sv
// ----------------------------------------------------------------------------
// dexp_pkg
// types, phase codes and character classes of the decimal exit status parser
// ----------------------------------------------------------------------------
package dexp_pkg;

    localparam int          C_MAX_DIGITS = 19;
    localparam logic [4:0]  C_COUNT_SAT  = 5'd20;
    localparam logic [63:0] C_LIMIT_POS  = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] C_LIMIT_NEG  = 64'h8000_0000_0000_0000;

    localparam logic [7:0]  C_CHAR_PLUS  = 8'h2B;
    localparam logic [7:0]  C_CHAR_MINUS = 8'h2D;
    localparam logic [7:0]  C_CHAR_ZERO  = 8'h30;
    localparam logic [7:0]  C_CHAR_NINE  = 8'h39;
    localparam logic [7:0]  C_CHAR_TAB   = 8'h09;
    localparam logic [7:0]  C_CHAR_CR    = 8'h0D;
    localparam logic [7:0]  C_CHAR_SPACE = 8'h20;

    localparam logic [2:0]  PH_LEAD   = 3'd0;
    localparam logic [2:0]  PH_SIGNED = 3'd1;
    localparam logic [2:0]  PH_DIGITS = 3'd2;
    localparam logic [2:0]  PH_TRAIL  = 3'd3;
    localparam logic [2:0]  PH_BAD    = 3'd4;

    typedef struct packed {
        logic [7:0] ch;
        logic       end_mark;
    } t_item;

    typedef struct packed {
        logic              bad_number;
        logic signed [8:0] status;
    } t_result;

    function automatic logic is_blank(input logic [7:0] c);
        return ((c >= C_CHAR_TAB) && (c <= C_CHAR_CR)) || (c == C_CHAR_SPACE);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= C_CHAR_ZERO) && (c <= C_CHAR_NINE);
    endfunction

endpackage

// File: rtl/dexp_in_stage.sv
// ----------------------------------------------------------------------------
// dexp_in_stage
// input register holding one character or end marker transaction
// ----------------------------------------------------------------------------
module dexp_in_stage
    import dexp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    output logic  o_valid,
    input  logic  i_take,
    output t_item o_item
);

    logic  r_valid;
    logic  n_valid;
    t_item r_item;

    // free when empty or when the held item leaves this cycle
    assign o_ready = !r_valid || i_take;
    assign n_valid = o_ready ? i_valid : r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// File: rtl/dexp_scan.sv
// ----------------------------------------------------------------------------
// dexp_scan
// parse state, digit accumulation and end of string verdict
// ----------------------------------------------------------------------------
`include "decimal_exit_status_parser_top_macros.svh"

module dexp_scan
    import dexp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_item   i_item,
    input  logic    i_out_ready,
    output logic    o_take,
    output logic    o_res_valid,
    output t_result o_result
);

    logic [2:0]  r_phase;
    logic [2:0]  n_phase;
    logic        r_negative;
    logic        n_negative;
    logic [4:0]  r_count;
    logic [4:0]  n_count;
    logic [63:0] r_mag;
    logic [63:0] n_mag;
    logic [63:0] mag_times_ten;
    logic [63:0] limit;
    logic        take_digit;
    logic        bad;
    logic [7:0]  c;

    assign c = i_item.ch;

    // an end marker waits for room in the output register
    assign o_take      = i_valid && (!i_item.end_mark || i_out_ready);
    assign o_res_valid = o_take && i_item.end_mark;

    // times ten by shift and add, plus the digit's low nibble
    assign mag_times_ten = (r_mag << 3) + (r_mag << 1) + {60'd0, c[3:0]};

    always_comb begin
        take_digit = 1'b0;
        n_phase    = r_phase;
        n_negative = r_negative;
        case (r_phase)
            PH_LEAD: begin
                if (is_blank(c)) begin
                    n_phase = PH_LEAD;
                end else if (c == C_CHAR_PLUS) begin
                    n_phase = PH_SIGNED;
                end else if (c == C_CHAR_MINUS) begin
                    n_negative = 1'b1;
                    n_phase    = PH_SIGNED;
                end else if (is_digit(c)) begin
                    take_digit = 1'b1;
                end else begin
                    n_phase = PH_BAD;
                end
            end
            PH_SIGNED, PH_DIGITS: begin
                if (is_digit(c)) begin
                    take_digit = 1'b1;
                end else if (is_blank(c)) begin
                    n_phase = PH_TRAIL;
                end else begin
                    n_phase = PH_BAD;
                end
            end
            PH_TRAIL: begin
                if (!is_blank(c)) begin
                    n_phase = PH_BAD;
                end
            end
            default: begin
                n_phase = PH_BAD;
            end
        endcase
        if (take_digit) begin
            n_phase = PH_DIGITS;
        end
    end

    always_comb begin
        n_count = r_count;
        n_mag   = r_mag;
        if (take_digit && (r_count < C_COUNT_SAT)) begin
            n_count = r_count + 5'd1;
            n_mag   = mag_times_ten;
        end
    end

    // verdict on the state built up so far
    assign limit = r_negative ? C_LIMIT_NEG : C_LIMIT_POS;
    assign bad   = (r_phase > PH_TRAIL) || (r_count == 5'd0)
                || (r_count > 5'(C_MAX_DIGITS)) || (r_mag > limit);

    always_comb begin
        o_result.bad_number = bad;
        if (bad) begin
            o_result.status = 9'sd0;
        end else if (r_negative) begin
            o_result.status = 9'sd0 - $signed({1'b0, r_mag[7:0]});
        end else begin
            o_result.status = $signed({1'b0, r_mag[7:0]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_LEAD;
            r_negative <= 1'b0;
            r_count    <= 5'd0;
            r_mag      <= 64'd0;
        end else if (o_take) begin
            if (i_item.end_mark) begin
                r_phase    <= PH_LEAD;
                r_negative <= 1'b0;
                r_count    <= 5'd0;
                r_mag      <= 64'd0;
            end else begin
                r_phase    <= n_phase;
                r_negative <= n_negative;
                r_count    <= n_count;
                r_mag      <= n_mag;
            end
        end
    end

    `DEXP_ASSERT(a_count_sat, r_count <= C_COUNT_SAT, "digit count above saturation")
    `DEXP_ASSERT_IMPL(a_bad_zero, o_res_valid && o_result.bad_number, o_result.status == 9'sd0, "error result with nonzero status")
    `DEXP_ASSERT_NEXT(a_end_clears, o_res_valid, (r_phase == PH_LEAD) && (r_count == 5'd0) && !r_negative, "state not cleared after end marker")
    `DEXP_ASSERT_IMPL(a_stall_end, i_valid && i_item.end_mark && !i_out_ready, !o_take, "end marker taken without output room")

endmodule

// File: rtl/dexp_out_stage.sv
// ----------------------------------------------------------------------------
// dexp_out_stage
// result register toward the master side
// ----------------------------------------------------------------------------
module dexp_out_stage
    import dexp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_result i_result,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    logic    r_valid;
    logic    n_valid;
    t_result r_result;

    assign o_ready = !r_valid || i_ready;
    assign n_valid = o_ready ? i_valid : r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// File: rtl/decimal_exit_status_parser_top.sv
// ----------------------------------------------------------------------------
// decimal_exit_status_parser_top
// parses one decimal argument string; status is sign times magnitude mod 256
// ----------------------------------------------------------------------------
// path: the result of an end marker reaches the master side through the input
//   register, then the result register
// throughput: one transaction per cycle, except while an end marker waits
//   for room in the result register (combinational 64-bit times-ten step)
// reset: synchronous active-low i_rst_n clears both valid flags and the parse
//   state; the block is ready in the first cycle after reset
// ----------------------------------------------------------------------------
module decimal_exit_status_parser_top
    import dexp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side: one character, or the end of the string
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] ch
    input  logic        s_axis_tlast,   // end_mark
    // master side: one result per end marker
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [8:0] status (signed), [15:9] zero
    output logic        m_axis_tuser    // bad_number
);

    t_item   in_item;
    t_item   held_item;
    t_result scan_result;
    t_result out_result;
    logic    held_valid;
    logic    scan_take;
    logic    scan_res_valid;
    logic    out_ready;

    assign in_item.ch       = s_axis_tdata;
    assign in_item.end_mark = s_axis_tlast;

    // input register decouples the slave handshake from the parse logic
    dexp_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (in_item),
        .o_valid (held_valid),
        .i_take  (scan_take),
        .o_item  (held_item)
    );

    // character classification, digit accumulation and the final verdict
    dexp_scan u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (held_valid),
        .i_item      (held_item),
        .i_out_ready (out_ready),
        .o_take      (scan_take),
        .o_res_valid (scan_res_valid),
        .o_result    (scan_result)
    );

    // result register; characters keep flowing while a result waits here
    dexp_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (scan_res_valid),
        .o_ready  (out_ready),
        .i_result (scan_result),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (out_result)
    );

    // status in the low bits, zero padded to two bytes
    assign m_axis_tdata = {7'd0, out_result.status};
    assign m_axis_tuser = out_result.bad_number;

endmodule

// File: tb/sv/decimal_exit_status_parser_top_tb.sv
// ----------------------------------------------------------------------------
// decimal_exit_status_parser_top_tb
// self-checking bench for the decimal exit status parser: a table of short
// argument strings, then random strings, mostly well-formed numbers with some
// broken or pure-noise ones, each closed by an end marker. every result
// transaction is checked against a bit-accurate parse model kept here or a
// result typed into the table, while both stream sides idle and stall at random in several phases.
// ----------------------------------------------------------------------------
module decimal_exit_status_parser_top_tb;
    import dexp_pkg::*;

    localparam int WD_LIMIT     = 5000;  // cycles with no transaction on either side
    localparam int HOLD_CYCLES  = 300;   // long receiver hold-off, fills the block
    localparam int RAND_ITEMS   = 2000;  // random slave transactions, over four phases
    localparam int DRAIN_CYCLES = 8;     // margin after the last expected result
    localparam int SHOW_ERRORS  = 10;
    localparam int DIR_ROWS     = 26;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;    // [7:0] ch
    logic        s_axis_tlast;    // end_mark
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;    // [8:0] status (signed), [15:9] zero
    logic        m_axis_tuser;    // bad_number

    decimal_exit_status_parser_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // directed strings; expectation typed in only where it is plain to see
    typedef struct {
        string txt;
        bit    chk;   // use the typed result below instead of the parse model
        bit    bad;
        int    st;
    } t_arg_row;

    t_arg_row arg_table [DIR_ROWS] = '{
        '{"",                      1, 1, 0},    // empty string
        '{" \011 ",                1, 1, 0},    // blanks only
        '{"+",                     1, 1, 0},    // sign only
        '{" - ",                   1, 1, 0},    // sign inside blanks
        '{"0",                     1, 0, 0},
        '{"42",                    0, 0, 0},
        '{"+255",                  1, 0, 255},
        '{"-255",                  1, 0, -255},
        '{"256",                   1, 0, 0},
        '{"-1",                    1, 0, -1},
        '{"\011\012\013\014\015 7\011\015 ", 1, 0, 7},  // every blank code
        '{"1 2",                   1, 1, 0},    // digit after trailing blank
        '{"--5",                   1, 1, 0},    // second sign
        '{"- 5",                   1, 1, 0},    // blank between sign and digits
        '{"+-5",                   1, 1, 0},
        '{"12a",                   0, 0, 0},
        '{"/",                     1, 1, 0},    // just below the digit range
        '{"9:",                    1, 1, 0},    // just above the digit range
        '{"\377",                  1, 1, 0},    // top character code
        '{"9223372036854775807",   1, 0, 255},  // largest positive
        '{"9223372036854775808",   1, 1, 0},    // one past it
        '{"-9223372036854775808",  1, 0, 0},    // most negative value
        '{"-9223372036854775809",  1, 1, 0},
        '{"0000000000000000001",   1, 0, 1},    // longest digit run allowed
        '{"00000000000000000001",  1, 1, 0},    // one digit too many
        '{"-300",                  0, 0, 0}
    };

    string near_head = "922337203685477580";

    // parse model state
    logic [2:0]  pm_phase;
    logic        pm_neg;
    logic [4:0]  pm_ndig;
    logic [63:0] pm_mag;

    t_result     want_status_q [$];

    int items_sent    = 0;
    int strings_done  = 0;
    int results_seen  = 0;
    int rejects_seen  = 0;
    int error_count   = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_req      = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;

    // ------------------------------------------------------------------------
    // clock
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // parse model
    // ------------------------------------------------------------------------
    function automatic logic blank_char(input logic [7:0] c);
        return ((c >= C_CHAR_TAB) && (c <= C_CHAR_CR)) || (c == C_CHAR_SPACE);
    endfunction

    function automatic logic digit_char(input logic [7:0] c);
        return (c >= C_CHAR_ZERO) && (c <= C_CHAR_NINE);
    endfunction

    task automatic clear_parse();
        pm_phase = PH_LEAD;
        pm_neg   = 1'b0;
        pm_ndig  = '0;
        pm_mag   = '0;
    endtask

    // times ten plus digit, frozen once the count saturates
    task automatic add_digit(input logic [7:0] c);
        if (pm_ndig < C_COUNT_SAT) begin
            pm_mag  = pm_mag * 64'd10 + 64'(c - C_CHAR_ZERO);
            pm_ndig = pm_ndig + 5'd1;
        end
        pm_phase = PH_DIGITS;
    endtask

    task automatic parse_item(input logic [7:0] c, input logic last,
                              output logic done, output t_result res);
        logic [63:0] lim;
        logic [8:0]  low;
        done = 1'b0;
        res  = '0;
        if (!last) begin
            case (pm_phase)
                PH_LEAD: begin
                    if (blank_char(c)) begin
                    end else if (c == C_CHAR_PLUS) begin
                        pm_phase = PH_SIGNED;
                    end else if (c == C_CHAR_MINUS) begin
                        pm_neg   = 1'b1;
                        pm_phase = PH_SIGNED;
                    end else if (digit_char(c)) begin
                        add_digit(c);
                    end else begin
                        pm_phase = PH_BAD;
                    end
                end
                PH_SIGNED, PH_DIGITS: begin
                    if (digit_char(c))
                        add_digit(c);
                    else if (blank_char(c))
                        pm_phase = PH_TRAIL;
                    else
                        pm_phase = PH_BAD;
                end
                PH_TRAIL: begin
                    if (!blank_char(c))
                        pm_phase = PH_BAD;
                end
                default: pm_phase = PH_BAD;
            endcase
        end else begin
            lim = pm_neg ? C_LIMIT_NEG : C_LIMIT_POS;
            res.bad_number = (pm_phase > PH_TRAIL) || (pm_ndig == 5'd0)
                          || (int'(pm_ndig) > C_MAX_DIGITS) || (pm_mag > lim);
            low = {1'b0, pm_mag[7:0]};
            if (!res.bad_number)
                res.status = pm_neg ? 9'(9'd0 - low) : low;
            done = 1'b1;
            clear_parse();
        end
    endtask

    // ------------------------------------------------------------------------
    // slave side driver: one transaction, random idle cycles in front
    // ------------------------------------------------------------------------
    task automatic send_item(input logic [7:0] c, input logic last,
                             input bit typed_en, input t_result typed);
        logic    done;
        t_result res;
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
        parse_item(c, last, done, res);
        if (done) begin
            want_status_q.push_back(typed_en ? typed : res);
            strings_done++;
        end
    endtask

    // one of the five control blanks or a space
    function automatic logic [7:0] rand_blank();
        int r;
        r = $urandom_range(5);
        return (r == 5) ? C_CHAR_SPACE : C_CHAR_TAB + 8'(r);
    endfunction

    function automatic logic [7:0] rand_digit();
        return C_CHAR_ZERO + 8'($urandom_range(9));
    endfunction

    // mostly well-formed numbers, some with one character spoiled,
    // and some pure noise over the whole character range
    task automatic send_random_string();
        logic [7:0] txt [$];
        int         kind;
        int         pick;
        kind = $urandom_range(99);
        if (kind < 85) begin
            repeat ($urandom_range(3)) txt.push_back(rand_blank());
            case ($urandom_range(3))
                0:       txt.push_back(C_CHAR_PLUS);
                1:       txt.push_back(C_CHAR_MINUS);
                default: ;
            endcase
            pick = $urandom_range(99);
            if (pick < 65) begin
                repeat ($urandom_range(1, 4)) txt.push_back(rand_digit());
            end else if (pick < 80) begin
                repeat ($urandom_range(5, 18)) txt.push_back(rand_digit());
            end else if (pick < 92) begin
                // around the range limits, sometimes padded past 19 digits
                repeat ($urandom_range(2)) txt.push_back(C_CHAR_ZERO);
                for (int k = 0; k < near_head.len(); k++)
                    txt.push_back(near_head[k]);
                txt.push_back(C_CHAR_ZERO + 8'($urandom_range(3, 9)));
            end else begin
                repeat ($urandom_range(19, 22)) txt.push_back(rand_digit());
            end
            repeat ($urandom_range(2)) txt.push_back(rand_blank());
            if (kind >= 70)
                txt[$urandom_range(txt.size() - 1)] = 8'($urandom_range(255));
        end else begin
            repeat ($urandom_range(5)) txt.push_back(8'($urandom_range(255)));
        end
        foreach (txt[k])
            send_item(txt[k], 1'b0, 1'b0, '0);
        send_item(8'($urandom_range(255)), 1'b1, 1'b0, '0);
    endtask

    function automatic void note_error(input string msg);
        error_count++;
        if (error_count <= SHOW_ERRORS)
            $display("ERROR: %s", msg);
    endfunction

    // ------------------------------------------------------------------------
    // master side ready: random stalls plus an occasional long hold-off
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // result check: every master transaction against the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : check_result
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.bad_number = m_axis_tuser;
            got.status     = m_axis_tdata[8:0];
            results_seen++;
            if (got.bad_number)
                rejects_seen++;
            if (want_status_q.size() == 0) begin
                note_error($sformatf("result with nothing expected: bad=%0b status=%0d",
                                     got.bad_number, $signed(got.status)));
            end else begin
                want = want_status_q.pop_front();
                if (got.bad_number !== want.bad_number || got.status !== want.status
                    || m_axis_tdata[15:9] !== 7'd0)
                    note_error($sformatf(
                        "result %0d: expected bad=%0b status=%0d, got bad=%0b status=%0d pad=%h",
                        results_seen, want.bad_number, $signed(want.status),
                        got.bad_number, $signed(got.status), m_axis_tdata[15:9]));
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: too long without a transaction on either side
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WD_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", WD_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        t_result typed;
        int      target;
        int      drain;

        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        clear_parse();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed strings, no idling
        for (int r = 0; r < DIR_ROWS; r++) begin
            for (int k = 0; k < arg_table[r].txt.len(); k++)
                send_item(arg_table[r].txt[k], 1'b0, 1'b0, '0);
            typed.bad_number = arg_table[r].bad;
            typed.status     = 9'(arg_table[r].st);
            send_item(8'($urandom_range(255)), 1'b1, arg_table[r].chk, typed);
        end

        // random strings over four idling phases
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    hold_req++;      // long hold-off while the sender keeps pushing
                end
                1: begin
                    send_idle_pct  = 86;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 86;
                end
                default: begin
                    send_idle_pct  = 18;
                    recv_stall_pct = 18;
                end
            endcase
            target = items_sent + RAND_ITEMS / 4;
            while (items_sent < target)
                send_random_string();
        end

        @(negedge i_clk);
        s_axis_tvalid  <= 1'b0;
        recv_stall_pct = 0;

        drain = 0;
        while (want_status_q.size() != 0 && drain < WD_LIMIT) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (want_status_q.size() != 0)
            note_error($sformatf("%0d expected results never arrived",
                                 want_status_q.size()));

        $display("parsed %0d argument strings from %0d input transactions",
                 strings_done, items_sent);
        $display("checked %0d results (%0d rejected as non-numeric), %0d errors",
                 results_seen, rejects_seen, error_count);
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
